// File: src/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the symbol table of the base64 stream encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] LINE_LENGTH_RESET = 8'd76;
	localparam logic [6:0] CH_PAD            = 7'h3D;
	localparam logic [6:0] CH_NL             = 7'h0A;
	localparam logic [6:0] CH_PLUS           = 7'h2B;
	localparam logic [6:0] CH_SLASH          = 7'h2F;
	localparam logic [5:0] SEXTET_MASK       = 6'h3F;

	// register map
	localparam logic REG_LINE_LENGTH = 1'b0;

	// one group of output characters, decided by the front end
	typedef struct packed {
		logic [23:0] word;
		logic [1:0]  nbytes;
		logic        final_grp;
		logic        newline;
	} cmd_t;

	function automatic logic [6:0] b64_symbol(input logic [5:0] v);
		logic [6:0] r;
		if (v < 6'd26) begin
			r = 7'h41 + {1'b0, v};
		end else if (v < 6'd52) begin
			r = 7'h61 + {1'b0, v} - 7'd26;
		end else if (v < 6'd62) begin
			r = 7'h30 + {1'b0, v} - 7'd52;
		end else if (v == 6'd62) begin
			r = CH_PLUS;
		end else begin
			r = CH_SLASH;
		end
		return r;
	endfunction

endpackage

// File: src/b64e_in_if.sv
// ----------------------------------------------------------------------------
// b64e_in_if
// Byte channel into the encoder: valid/ready with at most one message byte per item.
// ----------------------------------------------------------------------------
interface b64e_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       end_of_message;

	modport source (output valid, output data_byte, output byte_valid,
		output end_of_message, input ready);
	modport sink (input valid, input data_byte, input byte_valid,
		input end_of_message, output ready);
endinterface

// File: src/b64e_out_if.sv
// ----------------------------------------------------------------------------
// b64e_out_if
// Character channel out of the encoder: valid/ready with one character per item.
// ----------------------------------------------------------------------------
interface b64e_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] out_char;
	logic       last_char;

	modport source (output valid, output out_char, output last_char, input ready);
	modport sink (input valid, input out_char, input last_char, output ready);
endinterface

// File: src/b64e_front.sv
// ----------------------------------------------------------------------------
// b64e_front
// Accepts bytes, collects 3-byte groups, tracks the line column and pushes
// one group command into the queue whenever a group is due.
// ----------------------------------------------------------------------------
module b64e_front (
	input  logic              clk,
	input  logic              arst_n,
	b64e_in_if.sink           in_ch,
	input  logic [7:0]        line_length,
	input  logic              q_full,
	output logic              push,
	output b64e_pkg::cmd_t    push_cmd
);
	import b64e_pkg::*;

	logic [15:0] held_q;
	logic [1:0]  held_cnt_q;
	logic [7:0]  col_q;
	logic        nl_owed_q;

	logic        accept;
	logic [15:0] held_n;
	logic [1:0]  held_cnt_n;
	logic        grp;
	logic [23:0] grp_word;
	logic [1:0]  grp_nbytes;
	logic        grp_final;
	logic [8:0]  col_sum;

	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && !q_full;
	assign col_sum     = {1'b0, col_q} + 9'd4;

	always_comb begin
		held_n     = held_q;
		held_cnt_n = held_cnt_q;
		grp        = 1'b0;
		grp_word   = {held_q, in_ch.data_byte};
		grp_nbytes = 2'd3;
		grp_final  = in_ch.end_of_message;
		if (in_ch.byte_valid) begin
			if (held_cnt_q >= 2'd2) begin
				grp        = 1'b1;
				held_n     = '0;
				held_cnt_n = 2'd0;
			end else if (held_cnt_q == 2'd1) begin
				held_n     = {held_q[15:8], in_ch.data_byte};
				held_cnt_n = 2'd2;
			end else begin
				held_n     = {in_ch.data_byte, 8'h00};
				held_cnt_n = 2'd1;
			end
		end
		// flush of a partial group at message end
		if (in_ch.end_of_message && held_cnt_n != 2'd0) begin
			grp        = 1'b1;
			grp_word   = {held_n, 8'h00};
			grp_nbytes = held_cnt_n;
			grp_final  = 1'b1;
		end
	end

	assign push               = accept && grp;
	assign push_cmd.word      = grp_word;
	assign push_cmd.nbytes    = grp_nbytes;
	assign push_cmd.final_grp = grp_final;
	assign push_cmd.newline   = nl_owed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q     <= '0;
			held_cnt_q <= '0;
			col_q      <= '0;
			nl_owed_q  <= 1'b0;
		end else if (accept) begin
			if (in_ch.end_of_message) begin
				held_q     <= '0;
				held_cnt_q <= '0;
				col_q      <= '0;
				nl_owed_q  <= 1'b0;
			end else begin
				held_q     <= held_n;
				held_cnt_q <= held_cnt_n;
				if (grp) begin
					if (col_sum >= {1'b0, line_length}) begin
						nl_owed_q <= 1'b1;
						col_q     <= '0;
					end else begin
						nl_owed_q <= 1'b0;
						col_q     <= col_sum[7:0];
					end
				end
			end
		end
	end

endmodule

// File: src/b64e_queue.sv
// ----------------------------------------------------------------------------
// b64e_queue
// Short first-in first-out queue of group commands between front and back.
// ----------------------------------------------------------------------------
module b64e_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  b64e_pkg::cmd_t    push_cmd,
	input  logic              pop,
	output logic              full,
	output logic              nonempty,
	output b64e_pkg::cmd_t    head
);
	import b64e_pkg::*;

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign nonempty = (cnt_q != '0);
	assign head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: src/b64e_back.sv
// ----------------------------------------------------------------------------
// b64e_back
// Takes group commands from the queue and emits one character per cycle
// into a registered output stage while the queue holds a command and the output is not stalled.
// ----------------------------------------------------------------------------
module b64e_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_nonempty,
	input  b64e_pkg::cmd_t    head,
	output logic              pop,
	b64e_out_if.source        out_ch
);
	import b64e_pkg::*;

	localparam logic [2:0] SLOT_NL = 3'd0;
	localparam logic [2:0] SLOT_C0 = 3'd1;
	localparam logic [2:0] SLOT_C1 = 3'd2;
	localparam logic [2:0] SLOT_C2 = 3'd3;
	localparam logic [2:0] SLOT_C3 = 3'd4;

	logic [2:0] slot_q;
	logic       out_valid_s1;
	logic [6:0] out_char_s1;
	logic       last_s1;

	logic [2:0] slot;
	logic       emit;
	logic [5:0] sextet;
	logic [6:0] ch;
	logic       last;

	// skip the newline slot when none is owed
	assign slot = (slot_q == SLOT_NL && !head.newline) ? SLOT_C0 : slot_q;
	assign emit = q_nonempty && (!out_valid_s1 || out_ch.ready);
	assign pop  = emit && (slot == SLOT_C3);

	always_comb begin
		sextet = '0;
		ch     = CH_NL;
		last   = 1'b0;
		unique case (slot)
			SLOT_C0: sextet = head.word[23:18] & SEXTET_MASK;
			SLOT_C1: sextet = head.word[17:12] & SEXTET_MASK;
			SLOT_C2: sextet = head.word[11:6] & SEXTET_MASK;
			SLOT_C3: sextet = head.word[5:0] & SEXTET_MASK;
			default: sextet = '0;
		endcase
		if (slot != SLOT_NL) begin
			ch = b64_symbol(sextet);
		end
		if ((slot == SLOT_C2 && head.nbytes < 2'd2) ||
			(slot == SLOT_C3 && head.nbytes < 2'd3)) begin
			ch = CH_PAD;
		end
		if (slot == SLOT_C3) begin
			last = head.final_grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q       <= SLOT_NL;
			out_valid_s1 <= 1'b0;
		end else begin
			if (emit) begin
				slot_q       <= (slot == SLOT_C3) ? SLOT_NL : slot + 3'd1;
				out_valid_s1 <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_char_s1 <= ch;
			last_s1     <= last;
		end
	end

	assign out_ch.valid     = out_valid_s1;
	assign out_ch.out_char  = out_char_s1;
	assign out_ch.last_char = last_s1;

endmodule

// File: src/base64_stream_encoder_top.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder_top
// Base64 stream encoder with line wrapping and an APB-style register port.
// ----------------------------------------------------------------------------
// a completed group is registered in the queue, and its characters then in the output stage
// throughput: one character per cycle from the back end while the output is not stalled, 4 or 5 per group
// bytes are taken every cycle while the 2-entry group queue has room
// reset: asynchronous, clears held bytes, line column and queue; line_length = 76
module base64_stream_encoder_top (
	input  logic        clk,
	input  logic        arst_n,
	b64e_in_if.sink     in_ch,
	b64e_out_if.source  out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import b64e_pkg::*;

	logic [7:0] line_length_q;
	logic       q_full;
	logic       q_nonempty;
	logic       push;
	logic       pop;
	cmd_t       push_cmd;
	cmd_t       head;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_LINE_LENGTH) ? {24'h0, line_length_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q <= LINE_LENGTH_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_LINE_LENGTH) begin
			line_length_q <= pwdata[7:0];
		end
	end

	b64e_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.line_length (line_length_q),
		.q_full      (q_full),
		.push        (push),
		.push_cmd    (push_cmd)
	);

	b64e_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.full     (q_full),
		.nonempty (q_nonempty),
		.head     (head)
	);

	b64e_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.head       (head),
		.pop        (pop),
		.out_ch     (out_ch)
	);

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the base64 stream encoder with line wrapping.
// A directed table covers known encodings, padding, empty messages and bare
// end markers. Random messages then run under several line lengths, set over
// the register port while the encoder is quiet. Both channels idle at random,
// and the receiver holds off once for a long stretch. Every output character
// is checked against the directed table or an in-bench encoder model.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import b64e_pkg::*;

	localparam int IDLE_LIMIT      = 1000;
	localparam int HOLD_OFF_CYCLES = 150;
	localparam int SETTLE_CYCLES   = 10;
	localparam logic [2:0] LL_ADDR = {REG_LINE_LENGTH, 2'b00};
	localparam logic [8*64-1:0] B64_ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	typedef struct packed {
		logic [6:0] ch;
		logic       last;
	} enc_char_t;

	typedef struct packed {
		logic [7:0]  data;
		logic        bv;
		logic        eom;
		logic        typed;
		logic [2:0]  n;
		logic [39:0] chars;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	b64e_in_if  in_ch ();
	b64e_out_if out_ch ();

	base64_stream_encoder_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	enc_char_t pending_chars[$];
	enc_char_t head_char;
	stim_row_t dir_rows [22];
	int        mismatches;
	bit        steady;
	int        hold_asks;
	int        bytes_to_go;

	// encoder model state
	logic [15:0] grp_bytes;
	logic [1:0]  grp_fill;
	int          line_col;
	bit          nl_due;
	logic [7:0]  line_len;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [6:0] sextet_char(input logic [5:0] v);
		logic [7:0] c;
		c = B64_ALPHABET[8*(63-v) +: 8];
		return c[6:0];
	endfunction

	function automatic void emit_quad(input logic [23:0] word, input int nbytes,
			input logic fin, ref enc_char_t res[$]);
		if (nl_due) begin
			res.push_back('{CH_NL, 1'b0});
			nl_due = 1'b0;
		end
		res.push_back('{sextet_char(word[23:18]), 1'b0});
		res.push_back('{sextet_char(word[17:12]), 1'b0});
		res.push_back('{(nbytes >= 2) ? sextet_char(word[11:6]) : CH_PAD, 1'b0});
		res.push_back('{(nbytes == 3) ? sextet_char(word[5:0]) : CH_PAD, fin});
		if (line_col + 4 >= line_len) begin
			nl_due = 1'b1;
			line_col = 0;
		end else begin
			line_col += 4;
		end
	endfunction

	function automatic void encode_item(input logic [7:0] b, input logic bv,
			input logic eom, ref enc_char_t res[$]);
		if (bv) begin
			if (grp_fill == 2'd2) begin
				grp_fill = 2'd0;
				emit_quad({grp_bytes, b}, 3, eom, res);
				grp_bytes = '0;
			end else if (grp_fill == 2'd1) begin
				grp_bytes[7:0] = b;
				grp_fill = 2'd2;
			end else begin
				grp_bytes = {b, 8'h00};
				grp_fill = 2'd1;
			end
		end
		if (eom) begin
			if (grp_fill != 2'd0)
				emit_quad({grp_bytes, 8'h00}, int'(grp_fill), 1'b1, res);
			// message end: a fresh line, owed newline dropped
			grp_bytes = '0;
			grp_fill = 2'd0;
			line_col = 0;
			nl_due = 1'b0;
		end
	endfunction

	task automatic offer_item(input logic [7:0] b, input logic bv, input logic eom,
			input logic use_typed, input logic [2:0] n, input logic [39:0] chars);
		enc_char_t fresh[$];
		logic [7:0] c;
		if (!steady) begin
			while ($urandom_range(0, 99) < 17) begin
				in_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.byte_valid <= bv;
		in_ch.end_of_message <= eom;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		encode_item(b, bv, eom, fresh);
		if (use_typed) begin
			fresh.delete();
			for (int k = 0; k < int'(n); k++) begin
				c = chars[8*(int'(n)-1-k) +: 8];
				fresh.push_back('{c[6:0], eom && (k == int'(n) - 1)});
			end
		end
		foreach (fresh[k])
			pending_chars.push_back(fresh[k]);
	endtask

	// quiet the encoder: every expected item out, then the pipeline drained
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic read_line_length(input logic [7:0] want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= LL_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata[7:0] !== want) begin
			$display("%0t: line_length readback expected %0d actual %0d",
				$time, want, prdata[7:0]);
			mismatches++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_line_length(input logic [7:0] v);
		settle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= LL_ADDR;
		pwdata <= {24'h0, v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		line_len = v;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		read_line_length(v);
	endtask

	// random messages; a phase may stop mid-message and the next one carries on
	task automatic run_random(input int items, input int min_len, input int max_len);
		int sent;
		int roll;
		sent = 0;
		while (sent < items) begin
			if (bytes_to_go < 0)
				bytes_to_go = $urandom_range(max_len, min_len);
			roll = $urandom_range(0, 99);
			if (roll < 5) begin
				offer_item(8'($urandom), 1'b0, 1'b0, 1'b0, 3'd0, 40'h0);
			end else if (bytes_to_go == 0) begin
				offer_item(8'($urandom), 1'b0, 1'b1, 1'b0, 3'd0, 40'h0);
				bytes_to_go = -1;
				sent++;
			end else if (bytes_to_go == 1 && roll < 75) begin
				offer_item(8'($urandom), 1'b1, 1'b1, 1'b0, 3'd0, 40'h0);
				bytes_to_go = -1;
				sent++;
			end else begin
				offer_item(8'($urandom), 1'b1, 1'b0, 1'b0, 3'd0, 40'h0);
				bytes_to_go--;
				sent++;
			end
		end
	endtask

	// output checker
	always @(posedge clk) begin
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (pending_chars.size() == 0) begin
				$display("%0t: out item expected none actual char %h last %b",
					$time, out_ch.out_char, out_ch.last_char);
				mismatches++;
			end else begin
				head_char = pending_chars.pop_front();
				if (out_ch.out_char !== head_char.ch) begin
					$display("%0t: out_char expected %h actual %h",
						$time, head_char.ch, out_ch.out_char);
					mismatches++;
				end
				if (out_ch.last_char !== head_char.last) begin
					$display("%0t: last_char expected %b actual %b",
						$time, head_char.last, out_ch.last_char);
					mismatches++;
				end
			end
		end
	end

	// receiver side: random stalls, plus one long hold-off on request
	initial begin
		int stall_left;
		int holds_done;
		stall_left = 0;
		holds_done = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (holds_done != hold_asks) begin
				holds_done = hold_asks;
				stall_left = HOLD_OFF_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else if (steady) begin
				out_ch.ready <= 1'b1;
			end else begin
				out_ch.ready <= ($urandom_range(0, 99) >= 17);
			end
		end
	end

	// watchdog: too long with no item moving on either channel
	initial begin
		int idle_run;
		idle_run = 0;
		while (idle_run < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
					(out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
				idle_run = 0;
			else
				idle_run++;
		end
		$display("base64_stream_encoder_top verification failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data_byte = '0;
		in_ch.byte_valid = 1'b0;
		in_ch.end_of_message = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		mismatches = 0;
		steady = 1'b0;
		hold_asks = 0;
		bytes_to_go = -1;
		grp_bytes = '0;
		grp_fill = 2'd0;
		line_col = 0;
		nl_due = 1'b0;
		line_len = LINE_LENGTH_RESET;

		// data, byte_valid, end, typed, count, characters
		dir_rows = '{
			'{8'h00, 1'b1, 1'b0, 1'b1, 3'd0, 40'h0},
			'{8'h00, 1'b1, 1'b0, 1'b1, 3'd0, 40'h0},
			'{8'h00, 1'b1, 1'b0, 1'b1, 3'd4, "AAAA"},
			'{8'hFF, 1'b1, 1'b0, 1'b1, 3'd0, 40'h0},
			'{8'hA5, 1'b0, 1'b0, 1'b1, 3'd0, 40'h0},
			'{8'hFF, 1'b1, 1'b0, 1'b1, 3'd0, 40'h0},
			'{8'hFF, 1'b1, 1'b1, 1'b1, 3'd4, "////"},
			'{8'h00, 1'b0, 1'b1, 1'b1, 3'd0, 40'h0},
			'{8'h4D, 1'b1, 1'b0, 1'b1, 3'd0, 40'h0},
			'{8'h61, 1'b1, 1'b0, 1'b1, 3'd0, 40'h0},
			'{8'h6E, 1'b1, 1'b1, 1'b1, 3'd4, "TWFu"},
			'{8'h4D, 1'b1, 1'b0, 1'b1, 3'd0, 40'h0},
			'{8'h61, 1'b1, 1'b1, 1'b1, 3'd4, "TWE="},
			'{8'h4D, 1'b1, 1'b1, 1'b1, 3'd4, "TQ=="},
			'{8'hFB, 1'b1, 1'b0, 1'b1, 3'd0, 40'h0},
			'{8'hFF, 1'b1, 1'b0, 1'b1, 3'd0, 40'h0},
			'{8'hBF, 1'b1, 1'b0, 1'b1, 3'd4, "+/+/"},
			'{8'h00, 1'b0, 1'b1, 1'b1, 3'd0, 40'h0},
			'{8'h3C, 1'b1, 1'b0, 1'b0, 3'd0, 40'h0},
			'{8'h5A, 1'b0, 1'b0, 1'b0, 3'd0, 40'h0},
			'{8'hC3, 1'b1, 1'b0, 1'b0, 3'd0, 40'h0},
			'{8'hFF, 1'b0, 1'b1, 1'b0, 3'd0, 40'h0}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		read_line_length(LINE_LENGTH_RESET);

		foreach (dir_rows[i])
			offer_item(dir_rows[i].data, dir_rows[i].bv, dir_rows[i].eom,
				dir_rows[i].typed, dir_rows[i].n, dir_rows[i].chars);

		// shortest lines, with the receiver holding off at the start
		set_line_length(8'd4);
		hold_asks++;
		run_random(40, 0, 14);

		// longest lines, long messages, no idling on either side
		set_line_length(8'd255);
		steady = 1'b1;
		run_random(210, 195, 230);
		steady = 1'b0;

		// usually lands mid-line, past the new length
		set_line_length(8'd5);
		run_random(30, 0, 10);

		set_line_length(8'($urandom_range(255, 4)));
		run_random(40, 0, 60);

		set_line_length(8'($urandom_range(100, 8)));
		run_random(50, 0, 90);

		settle();
		if (mismatches == 0)
			$display("base64_stream_encoder_top verification clean");
		else
			$display("base64_stream_encoder_top verification failed");
		$finish;
	end

endmodule
